// ===== design/ptop_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the tile placer.
// No dependencies.
package ptop_pkg;
  localparam int MAX_NODES_DEF = 16;
  localparam int COST_W = 32;
  localparam int SHIFT_W = 32;
  localparam int POS_W = 40;
  localparam int CNT_W = 5;
  localparam int TILE_W = 4;
  localparam logic [COST_W-1:0] NO_EDGE = '1;
  // 1000000.0 in Q20.12.
  localparam logic [COST_W-1:0] COST_LIMIT = 32'd4096000000;
  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 5'd4;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef struct packed {
    logic load;       // write the edge beat into the stores
    logic run_init;   // start a build: clear mask, place root
    logic scan_rd;    // issue a read for the current scan pair
    logic scan_eval;  // compare the returned cost
    logic scan_clr;   // clear the best tracker before a sweep
    logic place_rd;   // issue a read of the shifts of the best pair
    logic place;      // join the best tile and compute its position
    logic emit_tree;  // load output with the newest tree tile
    logic emit_rest;  // load output with the current leftover tile
    logic clr_wr;     // clear one cost entry
  } ptop_cmd_t;

  typedef struct packed {
    logic found;      // sweep found a usable edge
    logic rest_valid; // current leftover tile is outside the tree
  } ptop_sts_t;
endpackage

// ===== design/ptop_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module ptop_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== design/ptop_dp.sv =====
`timescale 1ns / 1ps
// Datapath: edge stores, tree order, positions, best-edge tracker, output register.
// Depends on ptop_pkg and ptop_ram.
module ptop_dp import ptop_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ptop_cmd_t                    cmd,
  input  logic [$clog2(MAX_NODES)-1:0] ord_t,
  input  logic [$clog2(MAX_NODES)-1:0] scan_v,
  input  logic [$clog2(MAX_NODES)-1:0] cnt,
  input  logic [$clog2(MAX_NODES)-1:0] rest_v,
  input  logic [2*$clog2(MAX_NODES)-1:0] clr_addr,
  input  logic [TILE_W-1:0]            in_node_a,
  input  logic [TILE_W-1:0]            in_node_b,
  input  logic [COST_W-1:0]            in_edge_cost,
  input  logic signed [SHIFT_W-1:0]    in_shift_x,
  input  logic signed [SHIFT_W-1:0]    in_shift_y,
  output ptop_sts_t                    sts,
  output logic [TILE_W-1:0]            o_tile,
  output logic signed [POS_W-1:0]      o_x,
  output logic signed [POS_W-1:0]      o_y,
  output logic                         o_reached
);
  localparam int NW = $clog2(MAX_NODES);
  localparam int AW = 2 * NW;
  localparam int DEPTH = 1 << AW;
  localparam logic signed [POS_W:0] PMAX = {2'b00, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W:0] PMIN = {2'b11, {(POS_W-1){1'b0}}};

  logic [MAX_NODES-1:0] mask_r;
  logic [NW-1:0]        order_r [MAX_NODES];
  logic signed [POS_W-1:0] px_r [MAX_NODES];
  logic signed [POS_W-1:0] py_r [MAX_NODES];

  // Load path: order the ends, negate with saturation when reversed.
  logic [NW-1:0] la, lb, lo, hi;
  logic ld_ok, swap;
  logic signed [SHIFT_W-1:0] lsx, lsy;
  function automatic logic signed [SHIFT_W-1:0] negs(input logic signed [SHIFT_W-1:0] v);
    logic signed [SHIFT_W-1:0] r;
    r = (v == {1'b1, {(SHIFT_W-1){1'b0}}}) ? {1'b0, {(SHIFT_W-1){1'b1}}} : -v;
    return r;
  endfunction
  always_comb begin
    la = NW'(in_node_a);
    lb = NW'(in_node_b);
    ld_ok = (in_node_a != in_node_b) &&
            (32'(in_node_a) < MAX_NODES) &&
            (32'(in_node_b) < MAX_NODES);
    swap = la > lb;
    lo = swap ? lb : la;
    hi = swap ? la : lb;
    lsx = swap ? negs(in_shift_x) : in_shift_x;
    lsy = swap ? negs(in_shift_y) : in_shift_y;
  end

  // Scan path: pair (order[t], v), read registered.
  logic [NW-1:0] su, su_r, sv_r;
  logic [AW-1:0] raddr, waddr;
  logic sval_r;
  logic [COST_W-1:0] cost_rd;
  logic signed [SHIFT_W-1:0] sx_rd, sy_rd;
  logic [NW-1:0] bu_r, bv_r;
  logic [COST_W-1:0] best_r;
  logic found_r;

  always_comb begin
    su = order_r[ord_t];
    if (cmd.place_rd) raddr = (bu_r < bv_r) ? {bu_r, bv_r} : {bv_r, bu_r};
    else raddr = (su < scan_v) ? {su, scan_v} : {scan_v, su};
    waddr = cmd.clr_wr ? clr_addr : {lo, hi};
  end

  logic cwe, swe;
  assign swe = cmd.load && ld_ok;
  assign cwe = swe || cmd.clr_wr;

  ptop_ram #(.WIDTH(COST_W), .DEPTH(DEPTH)) u_cost (
    .clk, .we(cwe), .waddr, .wdata(cmd.clr_wr ? NO_EDGE : in_edge_cost),
    .raddr, .rdata(cost_rd));
  ptop_ram #(.WIDTH(SHIFT_W), .DEPTH(DEPTH)) u_sx (
    .clk, .we(swe), .waddr, .wdata(lsx), .raddr, .rdata(sx_rd));
  ptop_ram #(.WIDTH(SHIFT_W), .DEPTH(DEPTH)) u_sy (
    .clk, .we(swe), .waddr, .wdata(lsy), .raddr, .rdata(sy_rd));

  // Placement: parent position plus oriented shift, saturated.
  logic signed [POS_W:0] nx, ny;
  logic signed [SHIFT_W-1:0] dx, dy;
  function automatic logic signed [POS_W-1:0] sat(input logic signed [POS_W:0] v);
    logic signed [POS_W-1:0] r;
    if (v > PMAX) r = PMAX[POS_W-1:0];
    else if (v < PMIN) r = PMIN[POS_W-1:0];
    else r = v[POS_W-1:0];
    return r;
  endfunction
  always_comb begin
    dx = sx_rd;
    dy = sy_rd;
    nx = (bu_r > bv_r) ? (POS_W+1)'(px_r[bu_r]) - (POS_W+1)'(dx)
                       : (POS_W+1)'(px_r[bu_r]) + (POS_W+1)'(dx);
    ny = (bu_r > bv_r) ? (POS_W+1)'(py_r[bu_r]) - (POS_W+1)'(dy)
                       : (POS_W+1)'(py_r[bu_r]) + (POS_W+1)'(dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      sval_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      sval_r <= cmd.scan_rd && !mask_r[scan_v];
      if (cmd.run_init) mask_r <= MAX_NODES'(1);
      if (cmd.scan_clr) found_r <= 1'b0;
      if (cmd.scan_eval && sval_r && (cost_rd < (found_r ? best_r : COST_LIMIT)))
        found_r <= 1'b1;
      if (cmd.place) mask_r[bv_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    su_r <= su;
    sv_r <= scan_v;
    if (cmd.scan_eval && sval_r && (cost_rd < (found_r ? best_r : COST_LIMIT))) begin
      best_r <= cost_rd;
      bu_r <= su_r;
      bv_r <= sv_r;
    end
    if (cmd.run_init) begin
      order_r[0] <= '0;
      px_r[0] <= '0;
      py_r[0] <= '0;
      o_tile <= '0;
      o_x <= '0;
      o_y <= '0;
      o_reached <= 1'b1;
    end
    if (cmd.place) begin
      order_r[cnt] <= bv_r;
      px_r[bv_r] <= sat(nx);
      py_r[bv_r] <= sat(ny);
    end
    if (cmd.emit_tree) begin
      o_tile <= TILE_W'(bv_r);
      o_x <= px_r[bv_r];
      o_y <= py_r[bv_r];
      o_reached <= 1'b1;
    end
    if (cmd.emit_rest) begin
      o_tile <= TILE_W'(rest_v);
      o_x <= '0;
      o_y <= '0;
      o_reached <= 1'b0;
    end
  end

  assign sts.found = found_r;
  assign sts.rest_valid = !mask_r[rest_v];
endmodule

// ===== design/ptop_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences loads, Prim sweeps, emission and the cost clear.
// Depends on ptop_pkg.
module ptop_ctrl import ptop_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic                         cfg_we,
  input  logic [CNT_W-1:0]             cfg_node_count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_last,
  input  ptop_sts_t                    sts,
  output ptop_cmd_t                    cmd,
  output logic [$clog2(MAX_NODES)-1:0] ord_t,
  output logic [$clog2(MAX_NODES)-1:0] scan_v,
  output logic [$clog2(MAX_NODES)-1:0] cnt,
  output logic [$clog2(MAX_NODES)-1:0] rest_v,
  output logic [2*$clog2(MAX_NODES)-1:0] clr_addr
);
  localparam int NW = $clog2(MAX_NODES);
  localparam int AW = 2 * NW;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_REST = 3'd5;
  localparam logic [2:0] S_CLEAR = 3'd6;

  logic [2:0] st_r, st_nxt;
  logic [CNT_W-1:0] nc_r;
  logic [NW:0] n_eff, cnt_r, cnt_nxt;
  logic [NW-1:0] t_r, t_nxt, v_r, v_nxt, rv_r, rv_nxt;
  logic [AW-1:0] ca_r, ca_nxt;
  logic ov_r, ov_nxt, ol_r, ol_nxt;
  logic [1:0] dr_r, dr_nxt;
  logic out_free, in_acc;

  always_comb begin
    if (nc_r < CNT_W'(2)) n_eff = (NW+1)'(2);
    else if (32'(nc_r) > MAX_NODES) n_eff = (NW+1)'(MAX_NODES);
    else n_eff = (NW+1)'(nc_r);
  end

  assign out_free = !ov_r || !out_stall;
  assign in_stall = (st_r != S_IDLE) || !out_free;
  assign in_acc = in_valid && !in_stall;

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    t_nxt = t_r;
    v_nxt = v_r;
    rv_nxt = rv_r;
    ca_nxt = ca_r;
    dr_nxt = dr_r;
    ov_nxt = ov_r && out_stall;
    ol_nxt = ol_r;
    cmd = '0;
    unique case (st_r)
      S_IDLE: begin
        if (in_acc && in_op == OP_LOAD) cmd.load = 1'b1;
        if (in_acc && in_op == OP_START) begin
          cmd.run_init = 1'b1;
          cmd.scan_clr = 1'b1;
          ov_nxt = 1'b1;
          ol_nxt = 1'b0;
          cnt_nxt = (NW+1)'(1);
          t_nxt = '0;
          v_nxt = '0;
          st_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        cmd.scan_eval = 1'b1;
        if ((NW+1)'(v_r) == n_eff - 1'b1) begin
          v_nxt = '0;
          if ((NW+1)'(t_r) == cnt_r - 1'b1) begin
            dr_nxt = 2'd1;
            st_nxt = S_DRAIN;
          end else t_nxt = t_r + 1'b1;
        end else v_nxt = v_r + 1'b1;
      end
      S_DRAIN: begin
        cmd.scan_eval = 1'b1;
        st_nxt = S_PLACE;
      end
      S_PLACE: begin
        // While dr_r is set the place-address mux issues the shift read; the join uses its result.
        if (!sts.found) begin
          rv_nxt = '0;
          st_nxt = S_REST;
        end else if (dr_r == 2'd1) begin
          cmd.place_rd = 1'b1;
          dr_nxt = 2'd0;
        end else begin
          cmd.place = 1'b1;
          st_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit_tree = 1'b1;
          ov_nxt = 1'b1;
          cmd.scan_clr = 1'b1;
          t_nxt = '0;
          v_nxt = '0;
          cnt_nxt = cnt_r + 1'b1;
          ol_nxt = (cnt_r + 1'b1 == n_eff);
          if (cnt_r + 1'b1 == n_eff) begin
            ca_nxt = '0;
            st_nxt = S_CLEAR;
          end else st_nxt = S_SCAN;
        end
      end
      S_REST: begin
        if (!sts.rest_valid) begin
          if ((NW+1)'(rv_r) == n_eff - 1'b1) begin
            ca_nxt = '0;
            st_nxt = S_CLEAR;
          end else rv_nxt = rv_r + 1'b1;
        end else if (out_free) begin
          cmd.emit_rest = 1'b1;
          ov_nxt = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          ol_nxt = (cnt_r + 1'b1 == n_eff);
          if ((NW+1)'(rv_r) == n_eff - 1'b1) begin
            ca_nxt = '0;
            st_nxt = S_CLEAR;
          end else rv_nxt = rv_r + 1'b1;
        end
      end
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        ca_nxt = ca_r + 1'b1;
        if (ca_r == {AW{1'b1}}) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // The place-address mux presents the best pair while place_rd is set; S_PLACE
  // first issues that shift read, then joins the tile once the shifts return.
  // Reset starts with a clearing pass so the cost store reads "no edge".
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR;
      nc_r <= NODE_COUNT_RST;
      ov_r <= 1'b0;
      ol_r <= 1'b0;
      cnt_r <= '0;
      t_r <= '0;
      v_r <= '0;
      rv_r <= '0;
      ca_r <= '0;
      dr_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) nc_r <= cfg_node_count;
      ov_r <= ov_nxt;
      ol_r <= ol_nxt;
      cnt_r <= cnt_nxt;
      t_r <= t_nxt;
      v_r <= v_nxt;
      rv_r <= rv_nxt;
      ca_r <= ca_nxt;
      dr_r <= dr_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_last = ol_r;
  assign ord_t = t_r;
  assign scan_v = v_r;
  assign cnt = cnt_r[NW-1:0];
  assign rest_v = rv_r;
  assign clr_addr = ca_r;

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_acc) else $error("item accepted while busy");
  a_place_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.place |-> sts.found) else $error("placement without an edge");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SCAN) |-> (cnt_r < n_eff)) else $error("tree count overrun");
  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CLEAR && ca_r == {AW{1'b1}}) |=> (st_r == S_IDLE))
    else $error("clear pass did not end");
`endif
endmodule

// ===== design/prim_tree_offset_placer.sv =====
`timescale 1ns / 1ps
// Top level of the tile placer: minimum spanning tree over loaded edges.
// Depends on ptop_pkg, ptop_ctrl, ptop_dp (and ptop_ram below it).
//
// Usage: the input channel (in_valid/in_stall) takes one beat per unstalled cycle.
// A beat with in_op = 0 writes one edge (cost and x/y shift) into the edge
// stores and causes no result. A beat with in_op = 1 runs Prim's algorithm
// from tile 0 over node_count tiles (cfg_we/cfg_node_count, clamped 2..MAX).
// The result channel (out_valid/out_stall) then carries one beat per tile in
// tree order with out_last on the final one; unreachable tiles follow with
// out_reached low at position zero.
// The root beat appears the cycle after the start is accepted. Each further
// tile costs one sweep pairing every tree tile with each of the n tiles through
// the single read port of the cost store, then a drain, a shift read, the join
// and the emission. After the run a clearing pass writes all of the
// 2^(2*clog2(MAX_NODES)) cost entries (256 by default) back to "no edge", one
// per cycle; no beat is accepted meanwhile. Edge loads are accepted back to back.
// Reset (synchronous, rst_n low) returns node_count to 4 and starts the same
// clearing pass, so in_stall stays high until that pass ends.
// A receiver stall holds the result and pauses the build at its next emission.
module prim_tree_offset_placer import ptop_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_op,
  input  logic [TILE_W-1:0]         in_node_a,
  input  logic [TILE_W-1:0]         in_node_b,
  input  logic [COST_W-1:0]         in_edge_cost,
  input  logic signed [SHIFT_W-1:0] in_shift_x,
  input  logic signed [SHIFT_W-1:0] in_shift_y,
  input  logic                      cfg_we,
  input  logic [CNT_W-1:0]          cfg_node_count,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [TILE_W-1:0]         out_tile_index,
  output logic signed [POS_W-1:0]   out_pos_x,
  output logic signed [POS_W-1:0]   out_pos_y,
  output logic                      out_reached,
  output logic                      out_last
);
  localparam int NW = $clog2(MAX_NODES);
  localparam int AW = 2 * NW;

  ptop_cmd_t cmd;
  ptop_sts_t sts;
  logic [NW-1:0] ord_t, scan_v, cnt, rest_v;
  logic [AW-1:0] clr_addr;

  ptop_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .cfg_we, .cfg_node_count,
    .out_valid, .out_stall, .out_last, .sts, .cmd, .ord_t, .scan_v, .cnt,
    .rest_v, .clr_addr);

  ptop_dp #(.MAX_NODES(MAX_NODES)) u_dp (
    .clk, .rst_n, .cmd, .ord_t, .scan_v, .cnt, .rest_v, .clr_addr,
    .in_node_a, .in_node_b, .in_edge_cost, .in_shift_x, .in_shift_y, .sts,
    .o_tile(out_tile_index), .o_x(out_pos_x), .o_y(out_pos_y),
    .o_reached(out_reached));
endmodule

// ===== sim/prim_tree_offset_placer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for prim_tree_offset_placer: edge loads, tree builds
// and node_count settings, checked beat by beat against an in-bench predictor.
// Depends on ptop_pkg and the placer RTL only.
module prim_tree_offset_placer_tb;
  import ptop_pkg::*;

  // The cost store is cleared by a pass after each build (and after reset), so
  // the quiet time before a register write or the end must cover that pass.
  localparam int SETTLE_CYCLES = 400;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_BEATS = 400;

  typedef struct {
    logic [TILE_W-1:0]       tile;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic                    reached;
    logic                    last;
  } placement_t;

  // A directed row is either one input beat or one node_count write.
  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    logic                      op;
    logic [TILE_W-1:0]         a;
    logic [TILE_W-1:0]         b;
    logic [COST_W-1:0]         cost;
    logic signed [SHIFT_W-1:0] sx;
    logic signed [SHIFT_W-1:0] sy;
    int                        typed_cnt;  // results typed in below, 0 = use predictor
  } dir_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_op;
  logic [TILE_W-1:0]         in_node_a;
  logic [TILE_W-1:0]         in_node_b;
  logic [COST_W-1:0]         in_edge_cost;
  logic signed [SHIFT_W-1:0] in_shift_x;
  logic signed [SHIFT_W-1:0] in_shift_y;
  logic                      cfg_we;
  logic [CNT_W-1:0]          cfg_node_count;
  logic                      out_valid;
  logic                      out_stall;
  logic [TILE_W-1:0]         out_tile_index;
  logic signed [POS_W-1:0]   out_pos_x;
  logic signed [POS_W-1:0]   out_pos_y;
  logic                      out_reached;
  logic                      out_last;

  prim_tree_offset_placer DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_node_a      (in_node_a),
    .in_node_b      (in_node_b),
    .in_edge_cost   (in_edge_cost),
    .in_shift_x     (in_shift_x),
    .in_shift_y     (in_shift_y),
    .cfg_we         (cfg_we),
    .cfg_node_count (cfg_node_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_tile_index (out_tile_index),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_reached    (out_reached),
    .out_last       (out_last)
  );

  // Predictor state: its own copy of the edge stores and the tile count.
  logic [COST_W-1:0] edge_cost_mem [MAX_NODES_DEF*MAX_NODES_DEF];
  longint            edge_dx_mem [MAX_NODES_DEF*MAX_NODES_DEF];
  longint            edge_dy_mem [MAX_NODES_DEF*MAX_NODES_DEF];
  logic [CNT_W-1:0]  tile_count_reg;

  placement_t placements_due[$];
  int         error_count;
  int         cycle_count;
  int         burst_left;
  int         stall_mode;
  int         stall_mode_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The run never hangs: a stuck handshake ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic longint negate_sat32(longint v);
    return (v == -64'sd2147483648) ? 64'sd2147483647 : -v;
  endfunction

  function automatic longint clamp40(longint v);
    longint hi;
    hi = (64'sd1 <<< (POS_W - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic int pair_slot(int u, int v);
    return (u < v) ? u * MAX_NODES_DEF + v : v * MAX_NODES_DEF + u;
  endfunction

  function automatic void clear_costs();
    foreach (edge_cost_mem[i]) edge_cost_mem[i] = NO_EDGE;
  endfunction

  // An edge load: self edges are dropped, and an edge given high-to-low is
  // stored low-to-high with its shifts negated.
  function automatic void store_edge(int a, int b, logic [COST_W-1:0] cost,
                                     logic signed [SHIFT_W-1:0] sx,
                                     logic signed [SHIFT_W-1:0] sy);
    longint dx;
    longint dy;
    int s;
    dx = sx;
    dy = sy;
    if (a == b) return;
    if (a > b) begin
      dx = negate_sat32(dx);
      dy = negate_sat32(dy);
    end
    s = pair_slot(a, b);
    edge_cost_mem[s] = cost;
    edge_dx_mem[s] = dx;
    edge_dy_mem[s] = dy;
  endfunction

  function automatic void push_placement(int tile, longint x, longint y, bit reached,
                                         bit last);
    placement_t p;
    p.tile = tile[TILE_W-1:0];
    p.x = x[POS_W-1:0];
    p.y = y[POS_W-1:0];
    p.reached = reached;
    p.last = last;
    placements_due = {placements_due, p};
  endfunction

  // Prim's build from tile 0. The sweep walks tree tiles in join order and
  // outside tiles in ascending index; only a strictly lower cost replaces the
  // best, so ties go to the first pair found.
  function automatic void place_tiles();
    int     n;
    int     joined;
    int     join_order[MAX_NODES_DEF];
    bit     in_tree[MAX_NODES_DEF];
    longint px[MAX_NODES_DEF];
    longint py[MAX_NODES_DEF];
    logic [COST_W-1:0] best;
    int     bu;
    int     bv;
    bit     found;
    longint dx;
    longint dy;
    int     first;
    n = tile_count_reg;
    if (n < 2) n = 2;
    if (n > MAX_NODES_DEF) n = MAX_NODES_DEF;
    foreach (in_tree[i]) in_tree[i] = 1'b0;
    in_tree[0] = 1'b1;
    join_order[0] = 0;
    px[0] = 0;
    py[0] = 0;
    joined = 1;
    first = placements_due.size();
    push_placement(0, 0, 0, 1'b1, 1'b0);
    while (joined < n) begin
      best = COST_LIMIT;
      bu = 0;
      bv = 0;
      found = 1'b0;
      for (int t = 0; t < joined; t++) begin
        for (int v = 0; v < n; v++) begin
          if (!in_tree[v] && edge_cost_mem[pair_slot(join_order[t], v)] < best) begin
            best = edge_cost_mem[pair_slot(join_order[t], v)];
            bu = join_order[t];
            bv = v;
            found = 1'b1;
          end
        end
      end
      if (!found) break;
      dx = edge_dx_mem[pair_slot(bu, bv)];
      dy = edge_dy_mem[pair_slot(bu, bv)];
      if (bu > bv) begin
        dx = -dx;
        dy = -dy;
      end
      px[bv] = clamp40(px[bu] + dx);
      py[bv] = clamp40(py[bu] + dy);
      in_tree[bv] = 1'b1;
      join_order[joined++] = bv;
      push_placement(bv, px[bv], py[bv], 1'b1, 1'b0);
    end
    // Whatever the tree never reached follows in index order at the origin.
    for (int v = 0; v < n; v++) begin
      if (!in_tree[v]) push_placement(v, 0, 0, 1'b0, 1'b0);
    end
    placements_due[placements_due.size() - 1].last = 1'b1;
    if (placements_due.size() <= first) $error("predictor produced no placement");
    clear_costs();
  endfunction

  // One input beat, driven at the falling edge. The sender works in bursts;
  // when a burst runs out, valid may drop for a random gap before the next one.
  task automatic send_beat(logic op, logic [TILE_W-1:0] a, logic [TILE_W-1:0] b,
                           logic [COST_W-1:0] cost, logic signed [SHIFT_W-1:0] sx,
                           logic signed [SHIFT_W-1:0] sy);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid = 1'b1;
    in_op = op;
    in_node_a = a;
    in_node_b = b;
    in_edge_cost = cost;
    in_shift_x = sx;
    in_shift_y = sy;
    do @(posedge clk); while (in_stall);
    if (op == OP_LOAD) store_edge(a, b, cost, sx, sy);
    else place_tiles();
  endtask

  // Wait for the block to go quiet, including its clearing pass.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (placements_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Registers are written only with the block quiet.
  task automatic write_tile_count(logic [CNT_W-1:0] value);
    drain();
    cfg_we = 1'b1;
    cfg_node_count = value;
    @(negedge clk);
    cfg_we = 1'b0;
    tile_count_reg = value;
  endtask

  // Receiver: stalls in stretches of no, light or heavy back pressure.
  always @(negedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_mode_left = $urandom_range(8, 80);
    end else begin
      stall_mode_left--;
    end
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_stall <= ($urandom_range(0, 3) != 0);
      end
    endcase
  end

  // Every accepted result beat is matched against the oldest expectation.
  always @(posedge clk) begin
    placement_t p;
    if (rst_n && out_valid && !out_stall) begin
      if (placements_due.size() == 0) begin
        $error("result beat with nothing expected: tile %0d", out_tile_index);
        error_count++;
      end else begin
        p = placements_due.pop_front();
        if (out_tile_index !== p.tile) begin
          $error("tile_index: expected %0d, got %0d", p.tile, out_tile_index);
          error_count++;
        end
        if (out_pos_x !== p.x) begin
          $error("pos_x: expected %0d, got %0d", p.x, out_pos_x);
          error_count++;
        end
        if (out_pos_y !== p.y) begin
          $error("pos_y: expected %0d, got %0d", p.y, out_pos_y);
          error_count++;
        end
        if (out_reached !== p.reached) begin
          $error("reached: expected %0b, got %0b", p.reached, out_reached);
          error_count++;
        end
        if (out_last !== p.last) begin
          $error("last: expected %0b, got %0b", p.last, out_last);
          error_count++;
        end
      end
    end
  end

  function automatic logic [COST_W-1:0] pick_cost();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 15);  // small costs give plenty of ties
      4, 5, 6:    return $urandom();
      7:          return NO_EDGE;
      8:          return COST_LIMIT + $urandom_range(0, 2) - 1;
      default:    return $urandom_range(32'hFFFF_FFFE, COST_LIMIT);
    endcase
  endfunction

  function automatic logic signed [SHIFT_W-1:0] pick_shift();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2, 3:    return $urandom();
      default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  initial begin
    dir_row_t   rows[$];
    placement_t typed[$];
    int         beats;
    int         builds;
    int         n;
    int         mark;
    int         a;
    int         b;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_LOAD;
    in_node_a = '0;
    in_node_b = '0;
    in_edge_cost = '0;
    in_shift_x = '0;
    in_shift_y = '0;
    cfg_we = 1'b0;
    cfg_node_count = '0;
    out_stall = 1'b0;
    error_count = 0;
    cycle_count = 0;
    burst_left = 0;
    stall_mode = 0;
    stall_mode_left = 0;
    tile_count_reg = NODE_COUNT_RST;
    clear_costs();
    foreach (edge_dx_mem[i]) begin
      edge_dx_mem[i] = 0;
      edge_dy_mem[i] = 0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows. The root result of a build is always tile 0 at the origin.
    rows = '{
      // Empty store at the reset tile count: root, then three unreached tiles.
      '{ROW_BEAT, OP_START, 4'd9, 4'd3, 32'h1234_5678, 32'sd5, -32'sd5, 4},
      '{ROW_CFG, OP_LOAD, 4'd0, 4'd0, 32'd2, 32'sd0, 32'sd0, 0},
      // Extreme shifts on a zero-cost edge.
      '{ROW_BEAT, OP_LOAD, 4'd0, 4'd1, 32'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0},
      '{ROW_BEAT, OP_START, 4'd15, 4'd15, 32'hFFFF_FFFF, 32'sh8000_0000,
        32'sh7FFF_FFFF, 2},
      // Reversed edge: the most negative shift saturates when negated.
      '{ROW_BEAT, OP_LOAD, 4'd1, 4'd0, 32'd5, 32'sh8000_0000, 32'sd1, 0},
      '{ROW_BEAT, OP_START, 4'd0, 4'd0, 32'd0, 32'sd0, 32'sd0, 2},
      // Just under the cost limit still counts as an edge.
      '{ROW_BEAT, OP_LOAD, 4'd0, 4'd1, COST_LIMIT - 32'd1, 32'sd3, 32'sd4, 0},
      '{ROW_BEAT, OP_START, 4'd0, 4'd0, 32'd0, 32'sd0, 32'sd0, 0},
      // At the limit it does not.
      '{ROW_BEAT, OP_LOAD, 4'd0, 4'd1, COST_LIMIT, 32'sd3, 32'sd4, 0},
      '{ROW_BEAT, OP_START, 4'd0, 4'd0, 32'd0, 32'sd0, 32'sd0, 2},
      // A self edge is ignored.
      '{ROW_BEAT, OP_LOAD, 4'd0, 4'd0, 32'd1, 32'sd7, 32'sd7, 0},
      '{ROW_BEAT, OP_START, 4'd0, 4'd0, 32'd0, 32'sd0, 32'sd0, 2},
      // Full tile count: tie on cost, a duplicate load and a dead edge.
      '{ROW_CFG, OP_LOAD, 4'd0, 4'd0, 32'd16, 32'sd0, 32'sd0, 0},
      '{ROW_BEAT, OP_LOAD, 4'd0, 4'd15, 32'd7, 32'sd100, -32'sd100, 0},
      '{ROW_BEAT, OP_LOAD, 4'd15, 4'd3, 32'd2, 32'sd11, 32'sd12, 0},
      '{ROW_BEAT, OP_LOAD, 4'd3, 4'd5, 32'd2, -32'sd13, 32'sd14, 0},
      '{ROW_BEAT, OP_LOAD, 4'd0, 4'd5, NO_EDGE, 32'sd1, 32'sd1, 0},
      '{ROW_BEAT, OP_LOAD, 4'd0, 4'd15, 32'd1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0},
      '{ROW_BEAT, OP_START, 4'd0, 4'd0, 32'd0, 32'sd0, 32'sd0, 0},
      // Tile counts outside 2..16 are clamped.
      '{ROW_CFG, OP_LOAD, 4'd0, 4'd0, 32'd0, 32'sd0, 32'sd0, 0},
      '{ROW_BEAT, OP_LOAD, 4'd0, 4'd1, 32'd9, -32'sd1, -32'sd1, 0},
      '{ROW_BEAT, OP_START, 4'd0, 4'd0, 32'd0, 32'sd0, 32'sd0, 0},
      '{ROW_CFG, OP_LOAD, 4'd0, 4'd0, 32'd31, 32'sd0, 32'sd0, 0},
      '{ROW_BEAT, OP_START, 4'd0, 4'd0, 32'd0, 32'sd0, 32'sd0, 0}
    };
    typed = '{
      '{4'd0, 40'sd0, 40'sd0, 1'b1, 1'b0}, '{4'd1, 40'sd0, 40'sd0, 1'b0, 1'b0},
      '{4'd2, 40'sd0, 40'sd0, 1'b0, 1'b0}, '{4'd3, 40'sd0, 40'sd0, 1'b0, 1'b1},
      '{4'd0, 40'sd0, 40'sd0, 1'b1, 1'b0},
      '{4'd1, 40'sd2147483647, -40'sd2147483648, 1'b1, 1'b1},
      '{4'd0, 40'sd0, 40'sd0, 1'b1, 1'b0},
      '{4'd1, 40'sd2147483647, -40'sd1, 1'b1, 1'b1},
      '{4'd0, 40'sd0, 40'sd0, 1'b1, 1'b0}, '{4'd1, 40'sd0, 40'sd0, 1'b0, 1'b1},
      '{4'd0, 40'sd0, 40'sd0, 1'b1, 1'b0}, '{4'd1, 40'sd0, 40'sd0, 1'b0, 1'b1}
    };

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        write_tile_count(rows[i].cost[CNT_W-1:0]);
      end else begin
        mark = placements_due.size();
        send_beat(rows[i].op, rows[i].a, rows[i].b, rows[i].cost, rows[i].sx, rows[i].sy);
        if (rows[i].typed_cnt > 0) begin
          // The predictor kept the stores in step; the typed beats replace its list.
          while (placements_due.size() > mark) void'(placements_due.pop_back());
          repeat (rows[i].typed_cnt) placements_due = {placements_due, typed.pop_front()};
        end
      end
    end

    // Random part: mostly well-formed edge sets for the current tile count,
    // salted with self edges and tiles beyond the count, each closed by a build.
    beats = 0;
    builds = 0;
    while (beats < RANDOM_BEATS) begin
      if (builds % 4 == 0) begin
        case ($urandom_range(0, 19))
          0:          write_tile_count(CNT_W'($urandom_range(0, 1)));
          1:          write_tile_count(CNT_W'($urandom_range(17, 31)));
          2, 3, 4:    write_tile_count(CNT_W'(16));
          5, 6:       write_tile_count(CNT_W'($urandom_range(7, 15)));
          default:    write_tile_count(CNT_W'($urandom_range(2, 6)));
        endcase
      end
      n = tile_count_reg;
      if (n < 2) n = 2;
      if (n > MAX_NODES_DEF) n = MAX_NODES_DEF;
      repeat ($urandom_range(1, 3 * n)) begin
        if ($urandom_range(0, 9) == 0) begin
          a = $urandom_range(0, 15);
          b = ($urandom_range(0, 1) == 0) ? a : $urandom_range(0, 15);
        end else begin
          a = $urandom_range(0, n - 1);
          b = ($urandom_range(0, n - 2) + a + 1) % n;
        end
        send_beat(OP_LOAD, TILE_W'(a), TILE_W'(b), pick_cost(), pick_shift(),
                  pick_shift());
        if (a != b) beats++;
      end
      send_beat(OP_START, TILE_W'($urandom()), TILE_W'($urandom()), $urandom(),
                $urandom(), $urandom());
      beats++;
      builds++;
    end

    drain();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== prim_tree_offset_placer.f =====
design/ptop_pkg.sv
design/ptop_ram.sv
design/ptop_dp.sv
design/ptop_ctrl.sv
design/prim_tree_offset_placer.sv
sim/prim_tree_offset_placer_tb.sv
